// ----- rtl/core/llti_pkg.sv -----
// Package for the log-log table interpolator: payload types, widths, states.
// No dependencies.
package llti_pkg;

   localparam int PointCount = 64;
   localparam int IdxW       = 6;
   localparam int CntW       = 7;
   localparam int LogFrac    = 24;

   typedef struct packed {
      logic        command;
      logic [5:0]  point_index;
      logic [31:0] energy;
      logic [31:0] point_value;
   } req_type;

   typedef struct packed {
      logic [31:0] cross_section;
      logic        below_table;
      logic        above_table;
   } rsp_type;

   localparam logic CmdLoad  = 1'b0;
   localparam logic CmdQuery = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD0, ST_CHK0, ST_SCAN, ST_SCANW, ST_HIT, ST_RDA, ST_RDAW,
      ST_LX1, ST_LX2, ST_LQ, ST_LY1, ST_LY2, ST_MUL, ST_DIV, ST_DIVW,
      ST_EXP, ST_EXPW, ST_DONE
   } state_type;

   // log2 unit operands are 32 bit; result signed, 24 fractional bits
   typedef logic signed [31:0] log_type;

endpackage

// ----- rtl/core/log_log_table_interpolator_core.sv -----
// Top level of the log-log table interpolator; table memory and sequencer.
// Depends on llti_pkg, llti_log2, llti_divider, llti_exp2.

// Loads are accepted one per cycle while no query runs and no response is
// pending; they are written straight into the point memory. A query reads
// point 0, scans the points in use one entry at a time (one memory read port),
// rereads the two segment ends, then runs up to five log2 passes, a divider and
// a chain of 24 square roots. Below-table queries return once point 0 is read,
// exact hits after the scan, flat segments and zero values after the second
// log2. One request at a time.
module log_log_table_interpolator_core import llti_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic [6:0] csr_data
);

   logic [63:0] mem [PointCount];
   logic [63:0] rd_ff;
   logic [IdxW-1:0] raddr;
   logic        we;

   state_type st_ff, st_in;
   logic [CntW-1:0] n_ff, n_in;
   logic [CntW-1:0] nclamp;
   logic [CntW-1:0] j_ff, j_in;
   logic [IdxW-1:0] i_ff, i_in, a_ff, a_in;
   logic [31:0] q_ff, q_in, e1_ff, e1_in, e2_ff, e2_in, v1_ff, v1_in, v2_ff, v2_in;
   logic        above_ff, above_in, rdsel_ff, rdsel_in;
   log_type     lx1_ff, lx1_in, lx2_ff, lx2_in, lx_ff, lx_in, ly1_ff, ly1_in, ly2_ff, ly2_in;
   logic signed [63:0] num_ff, num_in;
   logic signed [31:0] dlx, dly;
   rsp_type     out_ff, out_in;
   logic        ov_ff, ov_in;

   logic        lg_start, lg_done, dv_start, dv_done, ex_start, ex_done;
   logic [31:0] lg_val;
   log_type     lg_res;
   logic signed [63:0] dv_quo, ex_y;
   logic [31:0] ex_res;

   llti_log2 u_log2 (.clock, .reset, .start(lg_start), .value(lg_val),
      .done(lg_done), .result(lg_res));
   llti_divider u_div (.clock, .reset, .start(dv_start), .num(num_ff),
      .den(64'(lx2_ff) - 64'(lx1_ff)), .done(dv_done), .quo(dv_quo));
   assign ex_y = 64'(ly1_ff) + dv_quo;
   llti_exp2 u_exp2 (.clock, .reset, .start(ex_start), .y(ex_y),
      .done(ex_done), .result(ex_res));

   // log2 values stay within +/-2^28, so the differences fit 32 bits
   assign dlx = lx_ff - lx1_ff;
   assign dly = ly2_ff - ly1_ff;

   assign nclamp = (n_ff < 7'd2) ? 7'd2 : ((n_ff > 7'(PointCount)) ? 7'(PointCount) : n_ff);
   assign req_stall = (st_ff != ST_IDLE) || ov_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = ov_ff;
   assign rsp_data = out_ff;
   assign we = req_valid && !req_stall && (req_data.command == CmdLoad);

   always_ff @(posedge clock) begin
      if (we) begin
         mem[req_data.point_index] <= {req_data.energy, req_data.point_value};
      end
      rd_ff <= mem[raddr];
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE:  if (req_valid && !req_stall && req_data.command == CmdQuery) st_in = ST_RD0;
         ST_RD0:   st_in = ST_CHK0;
         ST_CHK0:  st_in = (q_ff < rd_ff[63:32]) ? ST_DONE : ST_SCAN;
         ST_SCAN:  st_in = ST_SCANW;
         ST_SCANW: if (rd_ff[63:32] > q_ff || j_ff == nclamp - 7'd1) st_in = ST_HIT;
                   else st_in = ST_SCAN;
         ST_HIT:   st_in = (q_ff == e1_ff) ? ST_DONE : ST_RDA;
         ST_RDA:   st_in = ST_RDAW;
         ST_RDAW:  st_in = rdsel_ff ? ST_LX1 : ST_RDA;
         ST_LX1:   if (lg_done) st_in = ST_LX2;
         ST_LX2:   if (lg_done) st_in = (lg_res == lx1_ff || v1_ff == 0 || v2_ff == 0)
                                        ? ST_DONE : ST_LQ;
         ST_LQ:    if (lg_done) st_in = ST_LY1;
         ST_LY1:   if (lg_done) st_in = ST_LY2;
         ST_LY2:   if (lg_done) st_in = ST_MUL;
         ST_MUL:   st_in = ST_DIV;
         ST_DIV:   st_in = ST_DIVW;
         ST_DIVW:  if (dv_done) st_in = ST_EXP;
         ST_EXP:   st_in = ST_EXPW;
         ST_EXPW:  if (ex_done) st_in = ST_DONE;
         ST_DONE:  st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      n_in = csr_valid ? csr_data : n_ff;
      j_in = j_ff; i_in = i_ff; a_in = a_ff; q_in = q_ff;
      e1_in = e1_ff; e2_in = e2_ff; v1_in = v1_ff; v2_in = v2_ff;
      above_in = above_ff; rdsel_in = rdsel_ff;
      lx1_in = lx1_ff; lx2_in = lx2_ff; lx_in = lx_ff; ly1_in = ly1_ff; ly2_in = ly2_ff;
      num_in = num_ff; out_in = out_ff; ov_in = ov_ff && rsp_stall;
      raddr = '0; lg_start = 1'b0; lg_val = e1_ff; dv_start = 1'b0; ex_start = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            q_in = req_data.energy;
            out_in = '0;
            above_in = 1'b0;
         end
         ST_CHK0: begin
            if (q_ff < rd_ff[63:32]) out_in.below_table = 1'b1;
            j_in = 7'd1; i_in = '0;
            e1_in = rd_ff[63:32]; v1_in = rd_ff[31:0];
         end
         ST_SCAN: raddr = j_ff[IdxW-1:0];
         ST_SCANW: begin
            if (!(rd_ff[63:32] > q_ff)) begin
               i_in = j_ff[IdxW-1:0];
               e1_in = rd_ff[63:32]; v1_in = rd_ff[31:0];
            end
            j_in = j_ff + 7'd1;
         end
         ST_HIT: begin
            rdsel_in = 1'b0;
            if (q_ff == e1_ff) begin
               out_in.cross_section = v1_ff;
            end
            if ({1'b0, i_ff} == nclamp - 7'd1) begin
               above_in = 1'b1;
               a_in = 6'(nclamp - 7'd2);
            end else begin
               a_in = i_ff;
            end
         end
         ST_RDA: raddr = rdsel_ff ? a_ff + 6'd1 : a_ff;
         ST_RDAW: begin
            if (!rdsel_ff) begin
               e1_in = rd_ff[63:32]; v1_in = rd_ff[31:0];
            end else begin
               e2_in = rd_ff[63:32]; v2_in = rd_ff[31:0];
               lg_start = 1'b1; lg_val = e1_ff;
               out_in.above_table = above_ff;
            end
            rdsel_in = 1'b1;
         end
         ST_LX1: if (lg_done) begin lx1_in = lg_res; lg_start = 1'b1; lg_val = e2_ff; end
         ST_LX2: if (lg_done) begin
            lx2_in = lg_res;
            if (lg_res == lx1_ff) out_in.cross_section = v1_ff;
            lg_start = 1'b1; lg_val = q_ff;
         end
         ST_LQ:  if (lg_done) begin lx_in = lg_res; lg_start = 1'b1; lg_val = v1_ff; end
         ST_LY1: if (lg_done) begin ly1_in = lg_res; lg_start = 1'b1; lg_val = v2_ff; end
         ST_LY2: if (lg_done) ly2_in = lg_res;
         ST_MUL: num_in = dlx * dly;
         ST_DIV: dv_start = 1'b1;
         ST_EXP: ex_start = 1'b1;
         ST_EXPW: if (ex_done) out_in.cross_section = ex_res;
         ST_DONE: ov_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      j_ff <= j_in; i_ff <= i_in; a_ff <= a_in; q_ff <= q_in;
      e1_ff <= e1_in; e2_ff <= e2_in; v1_ff <= v1_in; v2_ff <= v2_in;
      above_ff <= above_in; rdsel_ff <= rdsel_in;
      lx1_ff <= lx1_in; lx2_ff <= lx2_in; lx_ff <= lx_in; ly1_ff <= ly1_in; ly2_ff <= ly2_in;
      num_ff <= num_in;
      if (!ov_ff) out_ff <= out_in;
      if (reset) begin
         st_ff <= ST_IDLE; n_ff <= 7'd2; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         n_ff <= n_in; ov_ff <= ov_in;
      end
   end

   a_busy: assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> req_stall) else $error("request taken while response pending");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> !(out_ff.below_table && out_ff.above_table)) else $error("both flags");
   a_below: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && out_ff.below_table) |-> out_ff.cross_section == 32'd0)
      else $error("below nonzero");

endmodule

// ----- rtl/core/llti_log2.sv -----
// Iterative fixed-point log2: one squaring per cycle, 24 fraction bits.
// Depends on llti_pkg.
module llti_log2 import llti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] value,
   output logic        done,
   output log_type     result
);

   logic [32:0] m_ff, m_in;
   logic [23:0] frac_ff, frac_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [4:0]  p_ff, p_in;
   logic        busy_ff, busy_in;
   logic [65:0] sq;
   logic [33:0] sh;
   logic [31:0] v;
   logic [4:0]  p;
   logic [23:0] frac_nxt;
   logic signed [5:0] ip;

   always_comb begin
      v = (value == 32'd0) ? 32'd1 : value;
      p = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            p = 5'(i);
         end
      end
   end

   assign sq = {33'd0, m_ff} * {33'd0, m_ff};
   assign sh = sq[64:31];
   assign frac_nxt = {frac_ff[22:0], sh[32]};

   always_comb begin
      m_in = m_ff;
      frac_in = frac_ff;
      cnt_in = cnt_ff;
      p_in = p_ff;
      busy_in = busy_ff;
      if (start) begin
         m_in = {1'b0, v << (5'd31 - p)};
         frac_in = '0;
         cnt_in = '0;
         p_in = p;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh[32]) begin
            m_in = sh[33:1];
         end else begin
            m_in = sh[32:0];
         end
         frac_in = frac_nxt;
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(LogFrac - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
      frac_ff <= frac_in;
      cnt_ff <= cnt_in;
      p_ff <= p_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // result is valid in the done cycle, even if a new start arrives with it
   assign done = busy_ff && (cnt_ff == 5'(LogFrac - 1));
   assign ip = $signed({1'b0, p_ff}) - 6'sd16;
   assign result = {{2{ip[5]}}, ip, frac_nxt};

endmodule

// ----- rtl/core/llti_divider.sv -----
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// Depends on llti_pkg.
module llti_divider import llti_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] num,
   input  logic signed [63:0] den,
   output logic               done,
   output logic signed [63:0] quo
);

   logic [63:0] q_ff, q_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        busy_ff, busy_in;
   logic [64:0] trial;

   assign trial = {r_ff, q_ff[63]} - {1'b0, d_ff};

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in = num[63] ? 64'(-num) : num;
         d_in = den[63] ? 64'(-den) : den;
         r_in = '0;
         cnt_in = '0;
         neg_in = num[63] ^ den[63];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            r_in = trial[63:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = {r_ff[62:0], q_ff[63]};
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign done = busy_ff && (cnt_ff == 7'd63);
   assign quo = neg_in ? 64'(-q_in) : q_in;

endmodule

// ----- rtl/core/llti_exp2.sv -----
// Iterative exp2: Horner chain of square roots, each sqrt bit-serial.
// Depends on llti_pkg.
module llti_exp2 import llti_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] y,
   output logic               done,
   output logic [31:0]        result
);

   // m <= 2^32 fits 33 bits; sqrt radicand m<<30 fits 64 bits
   logic [32:0] m_ff, m_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] bit_ff, bit_in;
   logic [23:0] f_ff, f_in;
   logic [4:0]  k_ff, k_in;
   logic [4:0]  b_ff, b_in;
   logic        sat_ff, sat_in, zero_ff, zero_in;
   logic        busy_ff, busy_in, rt_ff, rt_in;
   logic        done_ff, done_in;
   logic signed [63:0] t;
   logic [32:0] md;
   logic [63:0] rad;
   logic [63:0] fin;

   assign t = y + 64'sd268435456;
   assign md = f_ff[0] ? {m_ff[31:0], 1'b0} : m_ff;
   assign rad = {md[33-1:0], 30'd0} >> 0;

   always_comb begin
      m_in = m_ff; x_in = x_ff; r_in = r_ff; bit_in = bit_ff;
      f_in = f_ff; k_in = k_ff; b_in = b_ff; sat_in = sat_ff;
      zero_in = zero_ff; busy_in = busy_ff; rt_in = rt_ff;
      done_in = 1'b0;
      if (start) begin
         zero_in = t[63];
         sat_in = !t[63] && (t >= 64'sd536870912);
         f_in = t[23:0];
         k_in = t[28:24];
         m_in = 33'h040000000;
         b_in = '0;
         rt_in = 1'b0;
         busy_in = !(zero_in || sat_in);
         // out of range: no chain to run, answer right away
         done_in = zero_in || sat_in;
      end else if (busy_ff) begin
         if (!rt_ff) begin
            // load the radicand for this fraction bit
            x_in = rad;
            r_in = '0;
            bit_in = 64'h4000000000000000;
            rt_in = 1'b1;
         end else if (bit_ff != 64'd0) begin
            if (x_ff >= r_ff + bit_ff) begin
               x_in = x_ff - (r_ff + bit_ff);
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end else begin
            m_in = r_ff[32:0];
            f_in = f_ff >> 1;
            b_in = b_ff + 5'd1;
            rt_in = 1'b0;
            if (b_ff == 5'(LogFrac - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in; x_ff <= x_in; r_ff <= r_in; bit_ff <= bit_in;
      f_ff <= f_in; k_ff <= k_in; b_ff <= b_in; sat_ff <= sat_in;
      zero_ff <= zero_in; rt_ff <= rt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;

   // final scale on the registered mantissa, valid while done is high
   assign fin = ({31'd0, m_ff} << k_ff) >> 30;

   always_comb begin
      if (zero_ff) begin
         result = '0;
      end else if (sat_ff || (fin[63:32] != 32'd0)) begin
         result = 32'hFFFFFFFF;
      end else begin
         result = fin[31:0];
      end
   end

endmodule

// ----- dv/tb_log_log_table_interpolator_core.sv -----
// Self-checking bench for log_log_table_interpolator_core: table loads, log-log queries,
// points_in_use settings, random idling on both channels. Depends on llti_pkg and the RTL.
`timescale 1ns / 100ps

module tb_log_log_table_interpolator_core import llti_pkg::*;;

   localparam longint CycleLimit = 6000000;
   localparam int     DrainCycles = 1200;
   localparam longint OneLog = 64'sd1 << LogFrac;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [6:0] csr_data = '0;

   // predictor state
   logic [31:0] tbl_energy [PointCount];
   logic [31:0] tbl_value [PointCount];
   logic [6:0]  points_cfg;
   rsp_type     expected_xs [$];

   int     errors = 0;
   longint cycles = 0;
   int     burst_left = 0;
   int     stall_mode = 0;

   log_log_table_interpolator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver stalls: a random mode is picked periodically, mode 0 never stalls
   always @(posedge clock) begin
      if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 30);
         2: rsp_stall <= ($urandom_range(0, 99) < 75);
         default: rsp_stall <= (cycles % 7) < 3;
      endcase
   end

   // ---------------- predictor ----------------
   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint fx_log2(logic [31:0] v);
      int          p;
      logic [63:0] m;
      longint      frac;
      p = 31;
      frac = 0;
      if (v == 0) v = 1;
      while (v[p] == 1'b0) p--;
      m = {32'b0, v} << (31 - p);
      for (int i = 0; i < LogFrac; i++) begin
         m = (m * m) >> 31;
         frac = frac * 2;
         if (m >= (64'd1 << 32)) begin
            frac = frac | 1;
            m = m >> 1;
         end
      end
      return longint'(p - 16) * OneLog + frac;
   endfunction

   function automatic logic [31:0] fx_exp2(longint y);
      longint      t;
      logic [63:0] ut, m, r;
      int          k;
      t = y + 16 * OneLog;
      if (t < 0) return 32'd0;
      if (t >= 32 * OneLog) return 32'hFFFF_FFFF;
      ut = t;
      k = int'(ut >> LogFrac);
      m = 64'd1 << 30;
      for (int b = 0; b < LogFrac; b++) begin
         if (ut[b]) m = m << 1;
         m = int_sqrt(m << 30);
      end
      r = (m << k) >> 30;
      if (r > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return r[31:0];
   endfunction

   function automatic int active_points();
      if (points_cfg < 2) return 2;
      if (points_cfg > PointCount) return PointCount;
      return points_cfg;
   endfunction

   function automatic rsp_type interpolate_xs(logic [31:0] q);
      rsp_type r;
      int      n, i, a;
      longint  lx1, lx2, lx, ly1, ly2, num, den;
      r = '0;
      n = active_points();
      i = 0;
      if (q < tbl_energy[0]) begin
         r.below_table = 1'b1;
         return r;
      end
      for (int j = 0; j < n; j++) begin
         if (tbl_energy[j] > q) break;
         i = j;
      end
      if (q == tbl_energy[i]) begin
         r.cross_section = tbl_value[i];
         return r;
      end
      if (i == n - 1) begin
         r.above_table = 1'b1;
         a = n - 2;
      end else begin
         a = i;
      end
      lx1 = fx_log2(tbl_energy[a]);
      lx2 = fx_log2(tbl_energy[a + 1]);
      if (lx1 == lx2) begin
         r.cross_section = tbl_value[a];
         return r;
      end
      if (tbl_value[a] == 0 || tbl_value[a + 1] == 0) return r;
      lx = fx_log2(q);
      ly1 = fx_log2(tbl_value[a]);
      ly2 = fx_log2(tbl_value[a + 1]);
      num = (lx - lx1) * (ly2 - ly1);
      den = lx2 - lx1;
      r.cross_section = fx_exp2(ly1 + num / den);
      return r;
   endfunction

   // ---------------- drivers ----------------
   task automatic send_request(req_type item);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      if (item.command == CmdLoad) begin
         tbl_energy[item.point_index] = item.energy;
         tbl_value[item.point_index] = item.point_value;
      end else begin
         expected_xs.push_back(interpolate_xs(item.energy));
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 1200)) @(posedge clock);
         else repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 15);
      end
   endtask

   task automatic load_point(int idx, logic [31:0] e, logic [31:0] v);
      req_type item;
      item = '0;
      item.command = CmdLoad;
      item.point_index = 6'(idx);
      item.energy = e;
      item.point_value = v;
      send_request(item);
   endtask

   task automatic query_at(logic [31:0] e);
      req_type item;
      item.command = CmdQuery;
      item.point_index = 6'($urandom());
      item.energy = e;
      item.point_value = $urandom();
      send_request(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_xs.size() != 0) @(posedge clock);
   endtask

   task automatic write_points_in_use(logic [6:0] v);
      wait_drained();
      // a load may still be in flight with nothing expected
      repeat (60) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      points_cfg = v;
   endtask

   // ascending table over all slots, random spacing, some flat steps and zero values
   task automatic load_ascending_table();
      logic [63:0] e;
      logic [31:0] v;
      e = $urandom_range(1, 1 << 20);
      for (int i = 0; i < PointCount; i++) begin
         v = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom();
         load_point(i, e[31:0], v);
         if ($urandom_range(0, 19) != 0)
            e = e + (e >> $urandom_range(2, 6)) + $urandom_range(0, 1000);
         if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
      end
   endtask

   task automatic query_in_table();
      int          n, k, pick;
      logic [31:0] lo, hi;
      n = active_points();
      k = $urandom_range(0, n - 2);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         query_at(tbl_energy[k]);
      end else if (pick < 16 && tbl_energy[0] != 0) begin
         query_at($urandom_range(0, tbl_energy[0] - 1));
      end else if (pick < 24) begin
         lo = tbl_energy[n - 1];
         query_at($urandom_range(lo, 32'hFFFF_FFFF));
      end else begin
         lo = tbl_energy[k];
         hi = tbl_energy[k + 1];
         query_at(hi > lo ? $urandom_range(lo, hi) : lo);
      end
   endtask

   // ---------------- checking ----------------
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch @%0d: %s got %h want %h", cycles, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_xs.size() == 0) begin
            report_mismatch("unexpected request result", rsp_data.cross_section, 32'd0);
         end else begin
            want = expected_xs.pop_front();
            if (rsp_data.cross_section !== want.cross_section)
               report_mismatch("cross_section", rsp_data.cross_section, want.cross_section);
            if (rsp_data.below_table !== want.below_table)
               report_mismatch("below_table", 32'(rsp_data.below_table),
                               32'(want.below_table));
            if (rsp_data.above_table !== want.above_table)
               report_mismatch("above_table", 32'(rsp_data.above_table),
                               32'(want.above_table));
         end
      end
   end

   // ---------------- tests ----------------
   task automatic test_reset_defaults();
      load_ascending_table();
      query_at(tbl_energy[0]);
      query_at(tbl_energy[1]);
      query_at(tbl_energy[2]);
   endtask

   task automatic test_directed_cases();
      load_point(0, 32'h0001_0000, 32'h0010_0000);
      load_point(1, 32'h0010_0000, 32'h0000_1000);
      query_at(32'd0);
      query_at(32'h0000_FFFF);
      query_at(32'h0001_0000);
      query_at(32'h0004_0000);
      query_at(32'h0010_0000);
      query_at(32'hFFFF_FFFF);
      load_point(1, 32'h0001_0000, 32'hFFFF_FFFF);   // flat segment
      query_at(32'h0002_0000);
      load_point(1, 32'h0000_0100, 32'hFFFF_FFFF);
      load_point(0, 32'd0, 32'd0);                   // zero energy, zero value
      query_at(32'd0);
      query_at(32'd1);
      query_at(32'h0000_0080);
      load_point(0, 32'd1, 32'hFFFF_FFFF);
      load_point(1, 32'hFFFF_FFFF, 32'd1);
      query_at(32'h8000_0000);
      load_point(1, 32'd2, 32'hFFFF_FFFF);
      query_at(32'hFFFF_FFFF);                       // extrapolation far above the table, equal values
   endtask

   task automatic test_random_phase(logic [6:0] cfg, int count, bit rebuild, bit pause);
      int pick;
      write_points_in_use(cfg);
      if (rebuild) load_ascending_table();
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pause && i == count / 2) wait_drained();
         if (pick < 80) query_in_table();
         else if (pick < 90) load_point($urandom_range(0, PointCount - 1), $urandom(), $urandom());
         else query_at($urandom());
      end
   endtask

   initial begin
      points_cfg = 7'd2;
      for (int i = 0; i < PointCount; i++) begin
         tbl_energy[i] = '0;
         tbl_value[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_directed_cases();
      test_random_phase(7'd64, 20, 1'b1, 1'b1);
      test_random_phase(7'd0, 15, 1'b1, 1'b0);
      test_random_phase(7'd1, 10, 1'b0, 1'b0);
      test_random_phase(7'd127, 20, 1'b0, 1'b0);
      test_random_phase(7'd100, 15, 1'b1, 1'b0);
      test_random_phase(7'd17, 20, 1'b0, 1'b1);
      test_random_phase(7'd2, 15, 1'b0, 1'b0);
      test_random_phase(7'd33, 20, 1'b0, 1'b0);
      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/llti_pkg.sv
rtl/core/llti_log2.sv
rtl/core/llti_divider.sv
rtl/core/llti_exp2.sv
rtl/core/log_log_table_interpolator_core.sv
dv/tb_log_log_table_interpolator_core.sv
